/* rtl/bcc_pkg.sv */
// Shared types and constants of the block claim checker.
// Used by bcc_cfg_regs, bcc_claim_map and block_claim_checker; depends on nothing.
package bcc_pkg;

    localparam int MAP_BLOCKS_DEF  = 65536;
    localparam int WATCH_SLOTS_DEF = 4;
    localparam int WATCH_MAX       = 4;
    localparam int BLK_W           = 24;
    localparam int WORD_BITS       = 64;
    localparam int BIT_W           = 6;
    localparam int APB_ADDR_W      = 5;
    localparam int APB_DATA_W      = 32;
    localparam int REG_IDX_W       = 3;

    localparam logic [REG_IDX_W-1:0] REG_FIRST_DATA_BLOCK = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_VOLUME_BLOCKS    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DUP_CHECK_ENABLE = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_WATCH_BLOCK_0    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_WATCH_BLOCK_1    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_WATCH_BLOCK_2    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_WATCH_BLOCK_3    = 3'd6;

    localparam logic CMD_CLAIM = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    localparam logic [BLK_W-1:0] COUNT_MAX = {BLK_W{1'b1}};

    localparam int OUSER_OUT_OF_RANGE = 0;
    localparam int OUSER_DUPLICATE    = 1;
    localparam int OUSER_WATCHED_HIT  = 2;

    typedef struct packed {
        logic [BLK_W-1:0]                first_data_block;
        logic [BLK_W-1:0]                volume_blocks;
        logic                            dup_check_enable;
        logic [WATCH_MAX-1:0][BLK_W-1:0] watch_block;
    } bcc_cfg_t;

endpackage

/* rtl/bcc_cfg_regs.sv */
// APB configuration registers of the block claim checker.
// Depends on bcc_pkg for the register indexes and the configuration struct.
module bcc_cfg_regs #(
    parameter int WATCH_SLOTS = bcc_pkg::WATCH_SLOTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bcc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [bcc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [bcc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output bcc_pkg::bcc_cfg_t               cfg
);
    import bcc_pkg::*;

    logic [BLK_W-1:0]                first_reg;
    logic [BLK_W-1:0]                volume_reg;
    logic                            dup_en_reg;
    logic [WATCH_MAX-1:0][BLK_W-1:0] watch_reg;
    logic [REG_IDX_W-1:0]            idx;
    logic                            wr_en;
    logic [WATCH_MAX-1:0][BLK_W-1:0] watch_used;

    assign pready = 1'b1;
    assign idx    = paddr[APB_ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        for (int i = 0; i < WATCH_MAX; i++)
        begin
            watch_used[i] = (i < WATCH_SLOTS) ? watch_reg[i] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg  <= BLK_W'(1);
            volume_reg <= BLK_W'(2);
            dup_en_reg <= 1'b1;
            watch_reg  <= '0;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_FIRST_DATA_BLOCK: first_reg     <= pwdata[BLK_W-1:0];
                REG_VOLUME_BLOCKS:    volume_reg    <= pwdata[BLK_W-1:0];
                REG_DUP_CHECK_ENABLE: dup_en_reg    <= pwdata[0];
                REG_WATCH_BLOCK_0:    watch_reg[0]  <= pwdata[BLK_W-1:0];
                REG_WATCH_BLOCK_1:    watch_reg[1]  <= pwdata[BLK_W-1:0];
                REG_WATCH_BLOCK_2:    watch_reg[2]  <= pwdata[BLK_W-1:0];
                REG_WATCH_BLOCK_3:    watch_reg[3]  <= pwdata[BLK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_FIRST_DATA_BLOCK: prdata = APB_DATA_W'(first_reg);
            REG_VOLUME_BLOCKS:    prdata = APB_DATA_W'(volume_reg);
            REG_DUP_CHECK_ENABLE: prdata = APB_DATA_W'(dup_en_reg);
            REG_WATCH_BLOCK_0:    prdata = APB_DATA_W'(watch_used[0]);
            REG_WATCH_BLOCK_1:    prdata = APB_DATA_W'(watch_used[1]);
            REG_WATCH_BLOCK_2:    prdata = APB_DATA_W'(watch_used[2]);
            REG_WATCH_BLOCK_3:    prdata = APB_DATA_W'(watch_used[3]);
            default:              prdata = '0;
        endcase
    end

    always_comb
    begin
        cfg.first_data_block = first_reg;
        cfg.volume_blocks    = volume_reg;
        cfg.dup_check_enable = dup_en_reg;
        cfg.watch_block      = watch_used;
    end

endmodule

/* rtl/bcc_claim_map.sv */
// Claim bitmap storage: one write port and one registered read port.
// Depends on bcc_pkg for the word width.
module bcc_claim_map #(
    parameter int WORDS  = 1024,
    parameter int WORD_W = 10
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [WORD_W-1:0]             waddr,
    input  logic [bcc_pkg::WORD_BITS-1:0] wdata,
    input  logic                          re,
    input  logic [WORD_W-1:0]             raddr,
    output logic [bcc_pkg::WORD_BITS-1:0] rdata
);
    import bcc_pkg::*;

    logic [WORD_BITS-1:0] mem_array [WORDS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_array[raddr];
        end
    end

endmodule

/* rtl/block_claim_checker.sv */
// Block claim checker top level: range test, bitmap read-modify-write and result register.
// Depends on bcc_pkg, bcc_cfg_regs and bcc_claim_map.
//
//   Channel   Direction  Transfer when              Contents
//   s_axis    in         s_axis_tvalid & tready     tuser: command; tdata: block number
//   m_axis    out        m_axis_tvalid & tready     tuser: flags; tdata: duplicate total
//   APB       in         psel & penable & pwrite    registers at byte address 4*i
//
// Each item is handled in two steps: the bitmap word is read when the transfer is taken and
// written back from the second stage; s_axis_tready stays low while an item is in that stage.
// After reset a clearing pass writes zeros to every map word, one word a cycle, through all
// (MAP_BLOCKS+63)/64 words; s_axis_tready stays low meanwhile.
// A finished result waits in the output register while the next item is read; that item
// holds in the second stage until the output register is free.
module block_claim_checker #(
    parameter int MAP_BLOCKS  = bcc_pkg::MAP_BLOCKS_DEF,
    parameter int WATCH_SLOTS = bcc_pkg::WATCH_SLOTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // bit 23:0 block_number
    input  logic [23:0]                     s_axis_tdata,
    // bit 0 command
    input  logic [0:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // bit 23:0 duplicate_total
    output logic [23:0]                     m_axis_tdata,
    // bit 0 out_of_range, bit 1 duplicate, bit 2 watched_hit
    output logic [2:0]                      m_axis_tuser,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bcc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [bcc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [bcc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import bcc_pkg::*;

    localparam int MAP_WORDS = (MAP_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam logic [WORD_W-1:0] LAST_WORD = WORD_W'(MAP_WORDS - 1);
    localparam logic [BLK_W:0]    MAP_LIM   = (BLK_W+1)'(MAP_BLOCKS);

    bcc_cfg_t cfg;

    logic                 clearing_reg;
    logic [WORD_W-1:0]    clr_addr_reg;
    logic                 s1_valid_reg;
    logic                 s1_cmd_reg;
    logic                 s1_ok_reg;
    logic                 s1_hit_reg;
    logic [BIT_W-1:0]     s1_bit_reg;
    logic [WORD_W-1:0]    s1_word_reg;
    logic [BLK_W-1:0]     dup_cnt_reg;
    logic [BLK_W-1:0]     dup_cnt_next;
    logic                 out_valid_reg;
    logic [2:0]           out_user_reg;
    logic [BLK_W-1:0]     out_data_reg;

    logic [BLK_W-1:0]     blk;
    logic [BLK_W-1:0]     offset;
    logic                 in_ok;
    logic                 in_hit;
    logic                 accept;
    logic                 s1_done;
    logic [WORD_BITS-1:0] rdata;
    logic                 cur_bit;
    logic                 claim_rmw;
    logic                 is_dup;
    logic                 map_we;
    logic [WORD_BITS-1:0] map_wdata;
    logic                 mem_we;
    logic [WORD_W-1:0]    mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;

    bcc_cfg_regs #(
        .WATCH_SLOTS (WATCH_SLOTS)
    ) u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign blk    = s_axis_tdata;
    assign offset = blk - cfg.first_data_block;
    assign in_ok  = (blk >= cfg.first_data_block) && (blk < cfg.volume_blocks)
                    && ({1'b0, offset} < MAP_LIM);

    always_comb
    begin
        in_hit = 1'b0;
        for (int i = 0; i < WATCH_SLOTS; i++)
        begin
            if ((cfg.watch_block[i] != '0) && (cfg.watch_block[i] == blk))
            begin
                in_hit = 1'b1;
            end
        end
    end

    assign s_axis_tready = !clearing_reg && !s1_valid_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s1_done       = s1_valid_reg && (!out_valid_reg || m_axis_tready);

    assign cur_bit   = rdata[s1_bit_reg];
    assign claim_rmw = s1_ok_reg && (s1_cmd_reg == CMD_CLAIM) && cfg.dup_check_enable;
    assign is_dup    = claim_rmw && cur_bit;
    assign map_we    = s1_done && s1_ok_reg
                       && ((s1_cmd_reg == CMD_CLEAR) || (claim_rmw && !cur_bit));
    assign map_wdata = (s1_cmd_reg == CMD_CLEAR) ? '0
                       : (rdata | (WORD_BITS'(1) << s1_bit_reg));

    assign dup_cnt_next = (is_dup && (dup_cnt_reg != COUNT_MAX))
                          ? dup_cnt_reg + BLK_W'(1) : dup_cnt_reg;

    assign mem_we    = clearing_reg || map_we;
    assign mem_waddr = clearing_reg ? clr_addr_reg : s1_word_reg;
    assign mem_wdata = clearing_reg ? '0 : map_wdata;

    bcc_claim_map #(
        .WORDS  (MAP_WORDS),
        .WORD_W (WORD_W)
    ) u_claim_map (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (accept),
        .raddr (offset[BIT_W +: WORD_W]),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            dup_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                if (clr_addr_reg == LAST_WORD)
                begin
                    clearing_reg <= 1'b0;
                end
                else
                begin
                    clr_addr_reg <= clr_addr_reg + WORD_W'(1);
                end
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_done)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_done)
            begin
                dup_cnt_reg   <= dup_cnt_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg  <= s_axis_tuser[0];
            s1_ok_reg   <= in_ok;
            s1_hit_reg  <= in_ok && (s_axis_tuser[0] == CMD_CLAIM) && in_hit;
            s1_bit_reg  <= offset[BIT_W-1:0];
            s1_word_reg <= offset[BIT_W +: WORD_W];
        end
        if (s1_done)
        begin
            out_user_reg[OUSER_OUT_OF_RANGE] <= !s1_ok_reg;
            out_user_reg[OUSER_DUPLICATE]    <= is_dup;
            out_user_reg[OUSER_WATCHED_HIT]  <= s1_hit_reg;
            out_data_reg                     <= dup_cnt_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tdata  = out_data_reg;

    a_no_accept_while_clearing : assert property (
        @(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !s_axis_tready
    ) else $error("input transfer possible during map clearing pass");

    a_count_monotonic : assert property (
        @(posedge clk) disable iff (!rst_n)
        1'b1 |=> (dup_cnt_reg >= $past(dup_cnt_reg))
    ) else $error("duplicate count decreased");

    a_dup_not_bad : assert property (
        @(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[OUSER_DUPLICATE]) |-> !m_axis_tuser[OUSER_OUT_OF_RANGE]
    ) else $error("duplicate reported on an out-of-range block");

    a_no_map_write_on_bad : assert property (
        @(posedge clk) disable iff (!rst_n)
        (!clearing_reg && mem_we) |-> (s1_valid_reg && s1_ok_reg)
    ) else $error("map written for an item without a valid block");

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench of block_claim_checker: directed and random claim and clear transfers,
// checked against a bit-accurate predictor of the claim bitmap held in a scoreboard class.
// Depends on bcc_pkg and the block_claim_checker RTL.
module testbench;
    import bcc_pkg::*;

    localparam int MAP_WORDS    = (MAP_BLOCKS_DEF + WORD_BITS - 1) / WORD_BITS;
    localparam int WATCH_IDX_W  = $clog2(WATCH_MAX);
    localparam int IDLE_LIMIT   = 6000;
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_HOLD    = 300;
    localparam int PHASE_ITEMS  = 80;

    typedef struct packed {
        logic             out_of_range;
        logic             duplicate;
        logic             watched_hit;
        logic [BLK_W-1:0] duplicate_total;
    } claim_result_t;

    class claim_scoreboard;
        logic [BLK_W-1:0]     first_blk;
        logic [BLK_W-1:0]     vol_blks;
        logic                 dup_on;
        logic [BLK_W-1:0]     watch [WATCH_MAX];
        logic [WORD_BITS-1:0] claim_words [MAP_WORDS];
        logic [BLK_W-1:0]     dup_count;
        claim_result_t        awaited [$];
        int                   errors;

        function new();
            first_blk = BLK_W'(1);
            vol_blks  = BLK_W'(2);
            dup_on    = 1'b1;
            dup_count = '0;
            errors    = 0;
            foreach (watch[i])
                watch[i] = '0;
            foreach (claim_words[i])
                claim_words[i] = '0;
        endfunction

        function void set_reg(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] value);
            case (idx)
                REG_FIRST_DATA_BLOCK: first_blk = value[BLK_W-1:0];
                REG_VOLUME_BLOCKS:    vol_blks  = value[BLK_W-1:0];
                REG_DUP_CHECK_ENABLE: dup_on    = value[0];
                REG_WATCH_BLOCK_0, REG_WATCH_BLOCK_1, REG_WATCH_BLOCK_2, REG_WATCH_BLOCK_3:
                    watch[WATCH_IDX_W'(idx - REG_WATCH_BLOCK_0)] = value[BLK_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_transfer(logic cmd, logic [BLK_W-1:0] blk);
            claim_result_t    r;
            logic [BLK_W-1:0] ofs;
            int               w;
            int               b;
            r   = '0;
            ofs = blk - first_blk;
            r.out_of_range = (blk < first_blk) || (blk >= vol_blks) ||
                             (int'(ofs) >= MAP_BLOCKS_DEF);
            if (!r.out_of_range)
            begin
                w = (int'(ofs) >> BIT_W) % MAP_WORDS;
                b = int'(ofs[BIT_W-1:0]);
                if (cmd == CMD_CLEAR)
                    claim_words[w] = '0;
                else
                begin
                    if (dup_on)
                    begin
                        if (claim_words[w][b])
                        begin
                            r.duplicate = 1'b1;
                            if (dup_count != COUNT_MAX)
                                dup_count = dup_count + 1'b1;
                        end
                        else
                            claim_words[w][b] = 1'b1;
                    end
                    for (int i = 0; i < WATCH_SLOTS_DEF; i++)
                        if (watch[i] != 0 && watch[i] == blk)
                            r.watched_hit = 1'b1;
                end
            end
            r.duplicate_total = dup_count;
            awaited.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 100)
                $display("mismatch: %s", msg);
        endtask

        task check_result(logic [2:0] flags, logic [BLK_W-1:0] total);
            claim_result_t e;
            if (awaited.size() == 0)
            begin
                report($sformatf("result transfer with none expected, total %0d", total));
                return;
            end
            e = awaited.pop_front();
            if (flags[OUSER_OUT_OF_RANGE] !== e.out_of_range)
                report($sformatf("out_of_range %b, expected %b",
                                 flags[OUSER_OUT_OF_RANGE], e.out_of_range));
            if (flags[OUSER_DUPLICATE] !== e.duplicate)
                report($sformatf("duplicate %b, expected %b",
                                 flags[OUSER_DUPLICATE], e.duplicate));
            if (flags[OUSER_WATCHED_HIT] !== e.watched_hit)
                report($sformatf("watched_hit %b, expected %b",
                                 flags[OUSER_WATCHED_HIT], e.watched_hit));
            if (total !== e.duplicate_total)
                report($sformatf("duplicate_total %0d, expected %0d",
                                 total, e.duplicate_total));
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [23:0]           s_axis_tdata;
    logic [0:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [23:0]           m_axis_tdata;
    logic [2:0]            m_axis_tuser;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    claim_scoreboard board;
    logic            calm;
    logic            hold_off_request;
    int              idle_cycles = 0;

    block_claim_checker dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 clk = ~clk;

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send(logic cmd, logic [BLK_W-1:0] blk);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= blk;
        s_axis_tuser  <= cmd;
        do
            @(posedge clk);
        while (!s_axis_tready);
        board.note_transfer(cmd, blk);
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (board.awaited.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        board.set_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure_area(logic [BLK_W-1:0] first, logic [BLK_W-1:0] vol, logic dup,
                                  logic empty_slot);
        apb_write(REG_FIRST_DATA_BLOCK, APB_DATA_W'(first));
        apb_write(REG_VOLUME_BLOCKS, APB_DATA_W'(vol));
        apb_write(REG_DUP_CHECK_ENABLE, APB_DATA_W'(dup));
        apb_write(REG_WATCH_BLOCK_0, first + $urandom_range(0, 159));
        apb_write(REG_WATCH_BLOCK_1, first + $urandom_range(0, 159));
        apb_write(REG_WATCH_BLOCK_2, first + $urandom_range(0, 159));
        apb_write(REG_WATCH_BLOCK_3, empty_slot ? '0 : first + $urandom_range(0, 159));
    endtask

    // Most transfers claim or clear blocks from a narrow window at the bottom of the data area,
    // so that duplicates and word clears are frequent; the rest are watched blocks, edges and random noise.
    task automatic run_random(int count, int pause_at);
        int               r;
        logic [BLK_W-1:0] span;
        logic [BLK_W-1:0] blk;
        logic             cmd;
        span = (board.vol_blks > board.first_blk) ? board.vol_blks - board.first_blk
                                                  : BLK_W'(1);
        if (span > 160)
            span = BLK_W'(160);
        for (int k = 0; k < count; k++)
        begin
            if (k == pause_at)
                wait_drained();
            r   = $urandom_range(0, 99);
            cmd = CMD_CLAIM;
            blk = board.first_blk + BLK_W'($urandom_range(0, span - 1));
            if (r < 62)
                ;
            else if (r < 72)
                cmd = CMD_CLEAR;
            else if (r < 82)
                blk = board.watch[WATCH_IDX_W'($urandom_range(0, WATCH_MAX - 1))];
            else if (r < 88)
            begin
                case ($urandom_range(0, 4))
                    0: blk = board.first_blk - BLK_W'(1);
                    1: blk = board.vol_blks;
                    2: blk = board.vol_blks - BLK_W'(1);
                    3: blk = board.first_blk + BLK_W'(MAP_BLOCKS_DEF - 1);
                    default: blk = board.first_blk + BLK_W'(MAP_BLOCKS_DEF);
                endcase
                cmd = 1'($urandom_range(0, 1));
            end
            else
            begin
                cmd = 1'($urandom_range(0, 1));
                blk = BLK_W'($urandom);
            end
            send(cmd, blk);
        end
    endtask

    initial
    begin : result_sink
        int   stall;
        logic nxt;
        stall = 0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                board.check_result(m_axis_tuser, m_axis_tdata);
            if (hold_off_request)
            begin
                stall            = LONG_HOLD;
                hold_off_request = 1'b0;
            end
            if (stall > 0)
            begin
                stall--;
                nxt = 1'b0;
            end
            else
            begin
                stall = pick_gap();
                nxt   = (stall == 0);
                if (stall > 0)
                    stall--;
            end
            m_axis_tready <= nxt;
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[block_claim_checker] ERROR");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [BLK_W-1:0] first;
        logic [BLK_W-1:0] vol;
        board            = new();
        calm             = 1'b0;
        hold_off_request = 1'b0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= CMD_CLAIM;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Smallest possible area: only block 1 is valid.
        apb_write(REG_FIRST_DATA_BLOCK, 1);
        apb_write(REG_VOLUME_BLOCKS, 2);
        send(CMD_CLAIM, 0);
        send(CMD_CLAIM, 1);
        send(CMD_CLAIM, 1);
        send(CMD_CLAIM, 2);
        send(CMD_CLEAR, 1);
        send(CMD_CLAIM, 1);
        send(CMD_CLEAR, 24'hFFFFFF);
        wait_drained();

        // Area larger than the map, so that the capacity limit decides.
        apb_write(REG_FIRST_DATA_BLOCK, 100);
        apb_write(REG_VOLUME_BLOCKS, 100 + MAP_BLOCKS_DEF + 50);
        apb_write(REG_WATCH_BLOCK_0, 100);
        apb_write(REG_WATCH_BLOCK_1, 100 + MAP_BLOCKS_DEF - 1);
        apb_write(REG_WATCH_BLOCK_2, APB_DATA_W'(24'hFFFFFF));
        apb_write(REG_WATCH_BLOCK_3, 0);
        send(CMD_CLAIM, 99);
        send(CMD_CLAIM, 100);
        send(CMD_CLAIM, BLK_W'(100 + MAP_BLOCKS_DEF - 1));
        send(CMD_CLAIM, BLK_W'(100 + MAP_BLOCKS_DEF));
        send(CMD_CLAIM, 24'hFFFFFF);
        send(CMD_CLAIM, 101);
        send(CMD_CLAIM, 101);
        send(CMD_CLEAR, 150);
        send(CMD_CLAIM, 101);
        send(CMD_CLEAR, BLK_W'(100 + MAP_BLOCKS_DEF - 1));
        send(CMD_CLAIM, BLK_W'(100 + MAP_BLOCKS_DEF - 1));
        wait_drained();

        // Duplicate checking off: the watch compare still applies.
        apb_write(REG_DUP_CHECK_ENABLE, 0);
        send(CMD_CLAIM, 100);
        send(CMD_CLAIM, 100);
        send(CMD_CLEAR, 100);
        send(CMD_CLAIM, 102);
        wait_drained();

        // Empty and inverted areas reject every number.
        apb_write(REG_FIRST_DATA_BLOCK, APB_DATA_W'(24'hFFFFFF));
        apb_write(REG_VOLUME_BLOCKS, APB_DATA_W'(24'hFFFFFF));
        apb_write(REG_DUP_CHECK_ENABLE, 1);
        send(CMD_CLAIM, 24'hFFFFFF);
        send(CMD_CLAIM, 24'hFFFFFE);
        wait_drained();
        apb_write(REG_FIRST_DATA_BLOCK, 5000);
        apb_write(REG_VOLUME_BLOCKS, 4000);
        send(CMD_CLAIM, 4500);
        send(CMD_CLEAR, 4500);
        wait_drained();

        first = BLK_W'($urandom_range(1, 4000));
        vol   = first + BLK_W'($urandom_range(64, 3000));
        for (int p = 0; p < 5; p++)
        begin
            calm = (p % 3 == 0);
            case (p)
                0: configure_area(1, 24'hFFFFFF, 1'b1, 1'b0);
                1: configure_area(first, vol, 1'b1, 1'b1);
                2: configure_area(first, vol, 1'b0, 1'b0);
                3: configure_area(24'hFFFF40, 24'hFFFFFF, 1'b1, 1'b1);
                default: configure_area(200, BLK_W'(200 + MAP_BLOCKS_DEF + 300), 1'b1, 1'b0);
            endcase
            if (p == 1)
                hold_off_request = 1'b1;
            run_random(PHASE_ITEMS, (p == 2) ? PHASE_ITEMS / 2 : -1);
            wait_drained();
        end

        if (board.errors == 0)
            $display("[block_claim_checker] OK");
        else
            $display("[block_claim_checker] ERROR");
        $finish;
    end
endmodule
